FILE: rtl/sapc_pkg.sv
// shared types and constants of the sensor averaging and calibration core
`default_nettype none

package sapc_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned CAL_W    = 16;
    localparam int unsigned MV_W     = 14;
    localparam int unsigned TEMP_W   = 16;

    typedef struct packed {
        logic [SAMPLE_W-1:0] vbat_sample;
        logic [SAMPLE_W-1:0] temp_sample;
    } t_in_item;

    typedef struct packed {
        logic [MV_W-1:0]          vbat_millivolts;
        logic signed [TEMP_W-1:0] temp_centidegrees;
        logic                     cal_error;
    } t_out_item;

    typedef struct packed {
        logic [CAL_W-1:0] cal_low;
        logic [CAL_W-1:0] cal_high;
    } t_cal;

    // register indexes
    localparam logic CFG_CAL_LOW  = 1'b0;
    localparam logic CFG_CAL_HIGH = 1'b1;

    localparam logic [CAL_W-1:0] CAL_LOW_RST  = 16'd12252;
    localparam logic [CAL_W-1:0] CAL_HIGH_RST = 16'd16347;

    // 4 * 3300 mV full scale over a 65535 code range
    localparam logic [13:0] MV_SCALE   = 14'd13200;
    localparam logic [16:0] MV_DIVISOR = 17'd65535;

    // 80 degrees between calibration points, 30 degrees at the low point
    localparam logic [12:0] TEMP_SPAN   = 13'd8000;
    localparam logic [11:0] TEMP_OFFSET = 12'd3000;

    // window queue between accumulator and arithmetic
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // divider: quotient bits retired per cycle
    localparam int unsigned DIV_W      = 32;
    localparam int unsigned DIV_STEPS  = 4;
    localparam int unsigned DIV_CYCLES = DIV_W / DIV_STEPS;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG_MUL,
        S_AVG_BACK,
        S_AVG_FIX,
        S_PREP,
        S_NUM,
        S_DIV,
        S_DONE
    } t_back_state;

endpackage

`default_nettype wire

FILE: rtl/sapc_front.sv
// window accumulator: takes sample pairs and hands each finished window to the queue
`default_nettype none

module sapc_front #(
    parameter int unsigned WINDOW_PAIRS = 16,
    parameter int unsigned SUM_W        = 20
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  sapc_pkg::t_in_item   i_in_data,
    input  sapc_pkg::t_cal       i_cal,
    output logic                 o_push,
    input  wire                  i_push_ready,
    output logic [SUM_W-1:0]     o_push_vsum,
    output logic [SUM_W-1:0]     o_push_tsum,
    output sapc_pkg::t_cal       o_push_cal
);
    import sapc_pkg::*;

    localparam int unsigned CNT_W = $clog2(WINDOW_PAIRS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW_PAIRS - 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [SUM_W-1:0] r_vsum;
    logic [SUM_W-1:0] n_vsum;
    logic [SUM_W-1:0] r_tsum;
    logic [SUM_W-1:0] n_tsum;
    logic             last_pair;
    logic             accept;
    logic [SUM_W-1:0] vsum_add;
    logic [SUM_W-1:0] tsum_add;

    assign last_pair = (r_count == LAST_CNT);
    assign o_in_ready = !last_pair || i_push_ready;
    assign accept = i_in_valid && o_in_ready;

    assign vsum_add = r_vsum + SUM_W'(i_in_data.vbat_sample);
    assign tsum_add = r_tsum + SUM_W'(i_in_data.temp_sample);

    assign o_push      = accept && last_pair;
    assign o_push_vsum = vsum_add;
    assign o_push_tsum = tsum_add;
    assign o_push_cal  = i_cal;

    always_comb begin
        n_count = r_count;
        n_vsum  = r_vsum;
        n_tsum  = r_tsum;
        if (accept) begin
            if (last_pair) begin
                n_count = '0;
                n_vsum  = '0;
                n_tsum  = '0;
            end else begin
                n_count = r_count + 1'b1;
                n_vsum  = vsum_add;
                n_tsum  = tsum_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_vsum  <= '0;
            r_tsum  <= '0;
        end else begin
            r_count <= n_count;
            r_vsum  <= n_vsum;
            r_tsum  <= n_tsum;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sapc_queue.sv
// short queue of finished window sums between accumulator and arithmetic
`default_nettype none

module sapc_queue #(
    parameter int unsigned DATA_W = 72
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    output logic               o_push_ready,
    input  wire [DATA_W-1:0]   i_push_data,
    output logic               o_pop_valid,
    input  wire                i_pop,
    output logic [DATA_W-1:0]  o_pop_data
);
    import sapc_pkg::*;

    localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0]      r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];

    assign do_push = i_push && o_push_ready;
    assign do_pop  = i_pop && o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sapc_back.sv
// window arithmetic: averages, millivolt scaling and calibrated temperature division
`default_nettype none

module sapc_back #(
    parameter int unsigned WINDOW_PAIRS = 16,
    parameter int unsigned SUM_W        = 20
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_q_valid,
    output logic                 o_q_pop,
    input  wire [SUM_W-1:0]      i_q_vsum,
    input  wire [SUM_W-1:0]      i_q_tsum,
    input  sapc_pkg::t_cal       i_q_cal,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output sapc_pkg::t_out_item  o_out_data
);
    import sapc_pkg::*;

    localparam int unsigned PROD_W = 2 * SUM_W;
    localparam int unsigned QN_W   = SUM_W + SAMPLE_W;
    // floor(2^SUM_W / window): quotient estimate is low by at most one
    localparam logic [SUM_W-1:0] RECIP   = SUM_W'((64'd1 << SUM_W) / WINDOW_PAIRS);
    localparam logic [SUM_W-1:0] N_CONST = SUM_W'(WINDOW_PAIRS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);
    localparam logic signed [33:0] TEMP_MAX = 34'sd32767;
    localparam logic signed [33:0] TEMP_MIN = -34'sd32768;

    t_back_state r_state;
    t_back_state n_state;

    logic [SUM_W-1:0]     r_vsum;
    logic [SUM_W-1:0]     r_tsum;
    t_cal                 r_cal;
    logic [PROD_W-1:0]    r_prod_v;
    logic [PROD_W-1:0]    r_prod_t;
    logic [SAMPLE_W-1:0]  r_q0_v;
    logic [SAMPLE_W-1:0]  r_q0_t;
    logic [SUM_W-1:0]     r_qn_v;
    logic [SUM_W-1:0]     r_qn_t;
    logic [SAMPLE_W-1:0]  r_avg_v;
    logic [SAMPLE_W-1:0]  r_avg_t;
    logic [CAL_W-1:0]     r_absdiff;
    logic [CAL_W-1:0]     r_den;
    logic                 r_neg;
    logic                 r_err;
    logic [29:0]          r_mv_prod;
    logic [MV_W-1:0]      r_mv;
    logic [DIV_W-1:0]     r_dvd;
    logic [CAL_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 out_free;
    logic                 out_load;
    logic [SAMPLE_W-1:0]  q0_v;
    logic [SAMPLE_W-1:0]  q0_t;
    logic [QN_W-1:0]      qn_full_v;
    logic [QN_W-1:0]      qn_full_t;
    logic [SUM_W-1:0]     rem_v;
    logic [SUM_W-1:0]     rem_t;
    logic [MV_W-1:0]      mv_q0;
    logic [16:0]          mv_r;
    logic [MV_W-1:0]      mv_val;
    logic [28:0]          num_mag;
    logic [DIV_W-1:0]     dvd_next;
    logic [CAL_W-1:0]     rem_next;
    logic signed [33:0]   temp_base;
    logic signed [33:0]   temp_wide;
    logic signed [TEMP_W-1:0] temp_sat;

    assign out_free = !r_out_valid || i_out_ready;

    // average estimate and back-multiplication for the correction step
    assign q0_v = r_prod_v[SUM_W +: SAMPLE_W];
    assign q0_t = r_prod_t[SUM_W +: SAMPLE_W];
    assign qn_full_v = {{SUM_W{1'b0}}, q0_v} * {{SAMPLE_W{1'b0}}, N_CONST};
    assign qn_full_t = {{SUM_W{1'b0}}, q0_t} * {{SAMPLE_W{1'b0}}, N_CONST};
    assign rem_v = r_vsum - r_qn_v;
    assign rem_t = r_tsum - r_qn_t;

    // divide by 65535: quotient from the top bits, remainder below twice the divisor
    assign mv_q0  = r_mv_prod[29:16];
    assign mv_r   = {1'b0, r_mv_prod[15:0]} + {3'b000, mv_q0};
    assign mv_val = (mv_r >= MV_DIVISOR) ? mv_q0 + 1'b1 : mv_q0;

    assign num_mag = {13'd0, r_absdiff} * {16'd0, TEMP_SPAN};

    // restoring division, several quotient bits per cycle
    always_comb begin
        logic [16:0] trial;
        logic [CAL_W-1:0] rem_w;
        logic [DIV_W-1:0] dvd_w;
        rem_w = r_rem;
        dvd_w = r_dvd;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {rem_w, dvd_w[DIV_W-1]};
            dvd_w = {dvd_w[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial    = trial - {1'b0, r_den};
                dvd_w[0] = 1'b1;
            end
            rem_w = trial[CAL_W-1:0];
        end
        rem_next = rem_w;
        dvd_next = dvd_w;
    end

    // sign, offset and saturation
    assign temp_base = $signed({22'd0, TEMP_OFFSET});
    assign temp_wide = r_neg ? temp_base - $signed({2'b00, r_dvd})
                             : temp_base + $signed({2'b00, r_dvd});
    assign temp_sat = (temp_wide > TEMP_MAX) ? 16'sh7FFF :
                      (temp_wide < TEMP_MIN) ? 16'sh8000 : temp_wide[TEMP_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_AVG_MUL;
                end
            end
            S_AVG_MUL:  n_state = S_AVG_BACK;
            S_AVG_BACK: n_state = S_AVG_FIX;
            S_AVG_FIX:  n_state = S_PREP;
            S_PREP:     n_state = S_NUM;
            S_NUM:      n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE:  o_q_pop  = i_q_valid;
            S_DONE:  out_load = out_free;
            default: begin
                o_q_pop  = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_vsum <= i_q_vsum;
                    r_tsum <= i_q_tsum;
                    r_cal  <= i_q_cal;
                end
            end
            S_AVG_MUL: begin
                r_prod_v <= {{SUM_W{1'b0}}, r_vsum} * {{SUM_W{1'b0}}, RECIP};
                r_prod_t <= {{SUM_W{1'b0}}, r_tsum} * {{SUM_W{1'b0}}, RECIP};
            end
            S_AVG_BACK: begin
                r_q0_v <= q0_v;
                r_q0_t <= q0_t;
                r_qn_v <= qn_full_v[SUM_W-1:0];
                r_qn_t <= qn_full_t[SUM_W-1:0];
            end
            S_AVG_FIX: begin
                r_avg_v <= (rem_v >= N_CONST) ? r_q0_v + 1'b1 : r_q0_v;
                r_avg_t <= (rem_t >= N_CONST) ? r_q0_t + 1'b1 : r_q0_t;
            end
            S_PREP: begin
                r_absdiff <= (r_avg_t >= r_cal.cal_low) ? r_avg_t - r_cal.cal_low
                                                        : r_cal.cal_low - r_avg_t;
                r_den <= (r_cal.cal_high >= r_cal.cal_low)
                         ? r_cal.cal_high - r_cal.cal_low
                         : r_cal.cal_low - r_cal.cal_high;
                r_neg <= (r_avg_t < r_cal.cal_low) ^ (r_cal.cal_high < r_cal.cal_low);
                r_err <= (r_cal.cal_high == r_cal.cal_low);
                r_mv_prod <= {14'd0, r_avg_v} * {16'd0, MV_SCALE};
            end
            S_NUM: begin
                r_dvd <= {3'b000, num_mag};
                r_rem <= '0;
                r_cnt <= '0;
                r_mv  <= mv_val;
            end
            S_DIV: begin
                r_dvd <= dvd_next;
                r_rem <= rem_next;
                r_cnt <= r_cnt + 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.vbat_millivolts   <= r_mv;
                    r_out.temp_centidegrees <= r_err ? '0 : temp_sat;
                    r_out.cal_error         <= r_err;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/sensor_average_two_point_calibration_core.sv
// top level of the sensor averaging core with two-point temperature calibration
`default_nettype none

// Takes one battery/temperature sample pair per cycle unless a window's last pair
// waits for room in the queue, and sums both channels over WINDOW_PAIRS pairs.
// Each finished window moves through a two-entry queue to the arithmetic section,
// which forms the truncated averages, the battery voltage in millivolts and the
// calibrated temperature in hundredths of a degree, then holds the result in an
// output register until it is taken. The arithmetic section works on one window
// at a time through the average, scaling and temperature divider steps (4 quotient
// bits a cycle) and pops the next only after its result is loaded. Windows that
// arrive faster than it finishes them stall the input once the queue is full.
// Calibration words apply to windows completed after the write.

module sensor_average_two_point_calibration_core #(
    parameter int unsigned WINDOW_PAIRS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  sapc_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output sapc_pkg::t_out_item  o_out_data,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire [15:0]           i_cfg_wdata
);
    import sapc_pkg::*;

    localparam int unsigned SUM_W  = $clog2(WINDOW_PAIRS * ((1 << SAMPLE_W) - 1) + 1);
    localparam int unsigned DATA_W = 2 * SUM_W + $bits(t_cal);

    logic [CAL_W-1:0] r_cal_low;
    logic [CAL_W-1:0] r_cal_high;
    t_cal             cal;

    logic             push;
    logic             push_ready;
    logic [SUM_W-1:0] push_vsum;
    logic [SUM_W-1:0] push_tsum;
    t_cal             push_cal;
    logic             pop_valid;
    logic             pop;
    logic [DATA_W-1:0] pop_data;
    logic [SUM_W-1:0] pop_vsum;
    logic [SUM_W-1:0] pop_tsum;
    t_cal             pop_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_low  <= CAL_LOW_RST;
            r_cal_high <= CAL_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAL_LOW:  r_cal_low  <= i_cfg_wdata;
                CFG_CAL_HIGH: r_cal_high <= i_cfg_wdata;
                default: begin
                    r_cal_low <= r_cal_low;
                end
            endcase
        end
    end

    assign cal.cal_low  = r_cal_low;
    assign cal.cal_high = r_cal_high;

    sapc_front #(
        .WINDOW_PAIRS (WINDOW_PAIRS),
        .SUM_W        (SUM_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_cal        (cal),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_push_vsum  (push_vsum),
        .o_push_tsum  (push_tsum),
        .o_push_cal   (push_cal)
    );

    sapc_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_push_data  ({push_vsum, push_tsum, push_cal}),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_data   (pop_data)
    );

    assign pop_vsum = pop_data[DATA_W-1 -: SUM_W];
    assign pop_tsum = pop_data[DATA_W-SUM_W-1 -: SUM_W];
    assign pop_cal  = pop_data[$bits(t_cal)-1:0];

    sapc_back #(
        .WINDOW_PAIRS (WINDOW_PAIRS),
        .SUM_W        (SUM_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (pop_valid),
        .o_q_pop      (pop),
        .i_q_vsum     (pop_vsum),
        .i_q_tsum     (pop_tsum),
        .i_q_cal      (pop_cal),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

FILE: tb/tb_sensor_average_two_point_calibration_core.sv
`timescale 1ns / 1ps
// testbench of the sensor averaging core with two-point temperature calibration

module tb_sensor_average_two_point_calibration_core;
    import sapc_pkg::*;

    localparam int unsigned WINDOW            = 16;
    localparam int unsigned SETTLE_CYCLES     = 24;
    localparam int unsigned IDLE_LIMIT        = 4000;
    localparam int unsigned PHASES            = 9;
    localparam int unsigned WINDOWS_PER_PHASE = 13;

    class reading_scoreboard;
        logic [CAL_W-1:0] cal_low;
        logic [CAL_W-1:0] cal_high;
        logic [19:0]      vbat_sum;
        logic [19:0]      temp_sum;
        int unsigned      pair_count;
        t_out_item        expected_readings[$];
        int unsigned      mismatches;

        function new();
            cal_low    = CAL_LOW_RST;
            cal_high   = CAL_HIGH_RST;
            vbat_sum   = '0;
            temp_sum   = '0;
            pair_count = 0;
            mismatches = 0;
        endfunction

        function t_out_item predict_reading(logic [15:0] avg_v, logic [15:0] avg_t);
            t_out_item reading;
            longint    span;
            longint    centideg;
            reading.vbat_millivolts = 14'((longint'(avg_v) * 13200) / 65535);
            span = longint'(cal_high) - longint'(cal_low);
            if (span == 0) begin
                reading.temp_centidegrees = '0;
                reading.cal_error         = 1'b1;
            end else begin
                centideg = (longint'(avg_t) - longint'(cal_low)) * 8000 / span + 3000;
                if (centideg > 32767) centideg = 32767;
                if (centideg < -32768) centideg = -32768;
                reading.temp_centidegrees = 16'(centideg);
                reading.cal_error         = 1'b0;
            end
            return reading;
        endfunction

        function void take_pair(t_in_item pair);
            vbat_sum += pair.vbat_sample;
            temp_sum += pair.temp_sample;
            pair_count++;
            if (pair_count == WINDOW) begin
                expected_readings.push_back(
                    predict_reading(16'(vbat_sum / WINDOW), 16'(temp_sum / WINDOW)));
                vbat_sum   = '0;
                temp_sum   = '0;
                pair_count = 0;
            end
        endfunction

        function void check_reading(t_out_item got);
            t_out_item want;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reading: mv=%0d temp=%0d err=%0b",
                             got.vbat_millivolts, got.temp_centidegrees, got.cal_error);
                return;
            end
            want = expected_readings.pop_front();
            if (got.vbat_millivolts !== want.vbat_millivolts ||
                got.temp_centidegrees !== want.temp_centidegrees ||
                got.cal_error !== want.cal_error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reading mismatch: exp mv=%0d temp=%0d err=%0b, got mv=%0d temp=%0d err=%0b",
                             want.vbat_millivolts, want.temp_centidegrees, want.cal_error,
                             got.vbat_millivolts, got.temp_centidegrees, got.cal_error);
            end
        endfunction

        function int unsigned pending();
            return expected_readings.size();
        endfunction
    endclass

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    t_in_item         in_data     = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    t_out_item        out_data;
    logic             cfg_we      = 1'b0;
    logic             cfg_index   = CFG_CAL_LOW;
    logic [15:0]      cfg_wdata   = '0;

    reading_scoreboard sb;
    int unsigned       burst_left  = 0;
    int unsigned       idle_cycles = 0;
    logic [9:0]        stall_tick  = '0;
    logic [CAL_W-1:0]  cal_lows  [PHASES];
    logic [CAL_W-1:0]  cal_highs [PHASES];

    sensor_average_two_point_calibration_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: readings checked on transfer, ready follows a rotating stall pattern
    always @(posedge clk) begin
        stall_tick <= stall_tick + 1'b1;
        if (rst_n && out_valid && out_ready) begin
            sb.check_reading(out_data);
        end
        case (stall_tick[9:8])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (stall_tick[2:1] != 2'b11);
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    task automatic send_pair(input t_in_item pair);
        int unsigned gap;
        in_valid <= 1'b1;
        in_data  <= pair;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.take_pair(pair);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 24);
        end
    endtask

    function automatic t_in_item make_pair(int unsigned shape);
        t_in_item pair;
        int       lo;
        int       hi;
        int       code;
        case (shape)
            0: begin
                pair.vbat_sample = 16'($urandom);
                pair.temp_sample = 16'($urandom);
            end
            1: pair = '0;
            2: pair = '1;
            3: begin
                pair.vbat_sample = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                pair.temp_sample = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            default: begin
                // temperature codes around the calibration span
                lo   = (sb.cal_low < sb.cal_high) ? int'(sb.cal_low) : int'(sb.cal_high);
                hi   = (sb.cal_low < sb.cal_high) ? int'(sb.cal_high) : int'(sb.cal_low);
                code = int'($urandom_range(lo, hi)) + int'($urandom_range(0, 100)) - 50;
                if (code < 0) code = 0;
                if (code > 65535) code = 65535;
                pair.vbat_sample = 16'($urandom);
                pair.temp_sample = 16'(code);
            end
        endcase
        return pair;
    endfunction

    task automatic set_cal(input logic [CAL_W-1:0] low, input logic [CAL_W-1:0] high);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CAL_LOW;
        cfg_wdata <= low;
        @(posedge clk);
        sb.cal_low = low;
        cfg_index <= CFG_CAL_HIGH;
        cfg_wdata <= high;
        @(posedge clk);
        sb.cal_high = high;
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        int unsigned shape;
        sb = new();
        cal_lows  = '{CAL_LOW_RST, 16'd0, 16'hFFFF, 16'd1000, 16'd0, 16'hFFFF,
                      16'($urandom), 16'($urandom), CAL_LOW_RST};
        cal_highs = '{CAL_HIGH_RST, 16'hFFFF, 16'd0, 16'd1000, 16'd1, 16'hFFFE,
                      16'($urandom), 16'($urandom), CAL_HIGH_RST};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale battery with a cold sensor under reset calibration
        for (int i = 0; i < WINDOW; i++) begin
            send_pair(t_in_item'{16'hFFFF, 16'h0000});
        end

        for (int p = 0; p < PHASES; p++) begin
            in_valid <= 1'b0;
            wait_drained();
            set_cal(cal_lows[p], cal_highs[p]);
            for (int w = 0; w < WINDOWS_PER_PHASE; w++) begin
                shape = $urandom_range(0, 5);
                for (int i = 0; i < WINDOW; i++) begin
                    send_pair(make_pair(shape));
                end
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
